FILE: rtl/uniform_frame_window_sampler_core_defines.svh
// Assertion macros shared by the checker files.
// Both sample on the rising edge of clk and are disabled while rst is high.
`ifndef UNIFORM_FRAME_WINDOW_SAMPLER_CORE_DEFINES_SVH
`define UNIFORM_FRAME_WINDOW_SAMPLER_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define UFWS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define UFWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ufws_pkg.sv
package ufws_pkg;

  // Defaults for the top-level parameters
  localparam int DEPTH_DEF     = 64;
  localparam int TAG_WIDTH_DEF = 32;

  // Upper limit on the number of results in one sampling run
  localparam int MAX_SAMPLES = 64;

  // Fixed field widths
  localparam int CFG_W      = 7;
  localparam int IN_DATA_W  = 32;
  localparam int TAG_OUT_W  = 32;
  localparam int POS_W      = 6;
  localparam int OUT_DATA_W = ((TAG_OUT_W + POS_W + 7) / 8) * 8;

  // Register values after reset
  localparam logic [CFG_W-1:0] MAX_FRAMES_RST    = 7'd34;
  localparam logic [CFG_W-1:0] SAMPLE_FRAMES_RST = 7'd17;

  // Configuration register indexes
  typedef enum logic {
    REG_MAX_FRAMES    = 1'b0,
    REG_SAMPLE_FRAMES = 1'b1
  } cfg_reg_t;

  // Input command codes (carried on s_tuser)
  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

endpackage

FILE: rtl/ufws_ram.sv
module ufws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/uniform_frame_window_sampler_core.sv
// Channel   Dir  Beat contents
// s_*       in   tdata[31:0] frame_tag; tuser command (0 append, 1 sample)
// m_*       out  tdata[31:0] sampled_tag, [37:32] position; tlast last_of_run; tuser error
// cfg_*     in   cfg_index selects max_frames (0) or sample_frames (1); cfg_data value
//
// Append: tag written to the frame RAM in the accept cycle.
// Sample: serial division for the step size, then for each result a RAM read
//   state followed by an output register load state; error and
//   single-sample runs skip the divider.
// m_tready low holds the run in place; s_tready is high only between runs.
// Reset is synchronous; no clearing pass, the block accepts beats right after reset.
module uniform_frame_window_sampler_core #(
  parameter int DEPTH     = ufws_pkg::DEPTH_DEF,
  parameter int TAG_WIDTH = ufws_pkg::TAG_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ufws_pkg::IN_DATA_W-1:0]  s_tdata,   // [31:0] frame_tag
  input  logic                            s_tuser,   // [0] command
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ufws_pkg::OUT_DATA_W-1:0] m_tdata,   // [31:0] sampled_tag, [37:32] position
  output logic                            m_tlast,
  output logic                            m_tuser,   // [0] error
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [ufws_pkg::CFG_W-1:0]      cfg_data
);

  import ufws_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int HW  = $clog2(DEPTH + 1);
  localparam int DCW = $clog2(AW + 1);
  localparam logic [HW-1:0]    DEPTH_H   = HW'(DEPTH);
  localparam logic [HW:0]      DEPTH_H1  = (HW + 1)'(DEPTH);
  localparam logic [AW:0]      DEPTH_A1  = (AW + 1)'(DEPTH);
  localparam logic [CFG_W-1:0] MAX_K     = CFG_W'(MAX_SAMPLES);
  localparam logic [DCW-1:0]   DIV_STEPS = DCW'(AW);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_LOAD,
    ST_ERR
  } state_t;

  state_t state;

  // Configuration registers
  logic [CFG_W-1:0] max_frames;
  logic [CFG_W-1:0] sample_frames;

  // Window state
  logic [AW-1:0] oldest;
  logic [HW-1:0] held;

  // Run state
  logic [AW-1:0]    pos;
  logic [AW-1:0]    quo;
  logic [CFG_W-1:0] rem;
  logic [CFG_W-1:0] dv;
  logic [CFG_W:0]   racc;
  logic [CFG_W-1:0] cnt;
  logic [DCW-1:0]   dcnt;

  // Output register
  logic                 out_valid;
  logic [TAG_OUT_W-1:0] out_tag;
  logic [POS_W-1:0]     out_pos;
  logic                 out_last;
  logic                 out_err;

  // RAM ports
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [TAG_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [TAG_WIDTH-1:0] ram_rdata;

  logic accept;
  logic out_free;
  logic out_load;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign out_load = out_free && (state == ST_LOAD || state == ST_ERR);

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_DATA_W'({out_pos, out_tag});
  assign m_tlast  = out_last;
  assign m_tuser  = out_err;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frames    <= MAX_FRAMES_RST;
      sample_frames <= SAMPLE_FRAMES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_FRAMES:    max_frames    <= cfg_data;
        REG_SAMPLE_FRAMES: sample_frames <= cfg_data;
      endcase
    end
  end

  // Window capacity: zero or above depth means the whole store
  logic [HW-1:0] cap;
  always_comb begin
    if (max_frames == '0 || 32'(max_frames) > DEPTH) begin
      cap = DEPTH_H;
    end else begin
      cap = HW'(max_frames);
    end
  end

  // Append: drop one if full, write newest, then evict down to capacity
  logic          full;
  logic [AW:0]   inc_sum;
  logic [AW-1:0] old1;
  logic [HW-1:0] h0;
  logic [HW-1:0] h1;
  logic [AW:0]   wsum;
  logic [HW-1:0] drop;
  logic [HW:0]   osum;
  logic [AW-1:0] oldest_new;
  logic [HW-1:0] held_new;

  always_comb begin
    full    = (held == DEPTH_H);
    inc_sum = {1'b0, oldest} + 1'b1;
    if (full) begin
      old1 = (inc_sum >= DEPTH_A1) ? AW'(inc_sum - DEPTH_A1) : AW'(inc_sum);
      h0   = held - 1'b1;
    end else begin
      old1 = oldest;
      h0   = held;
    end
    wsum      = {1'b0, old1} + (AW + 1)'(h0);
    ram_waddr = (wsum >= DEPTH_A1) ? AW'(wsum - DEPTH_A1) : AW'(wsum);
    h1        = h0 + 1'b1;
    drop      = (h1 > cap) ? (h1 - cap) : '0;
    osum      = (HW + 1)'(old1) + {1'b0, drop};
    oldest_new = (osum >= DEPTH_H1) ? AW'(osum - DEPTH_H1) : AW'(osum);
    held_new   = (h1 > cap) ? cap : h1;
  end

  assign ram_we    = accept && (cmd_t'(s_tuser) == CMD_APPEND);
  assign ram_wdata = TAG_WIDTH'(s_tdata);

  // Read address: window position relative to the oldest slot
  logic [AW:0] rsum;
  assign rsum      = {1'b0, oldest} + {1'b0, pos};
  assign ram_raddr = (rsum >= DEPTH_A1) ? AW'(rsum - DEPTH_A1) : AW'(rsum);

  // Sample count limit
  logic [CFG_W-1:0] k_eff;
  logic [CFG_W-1:0] k_m1;
  assign k_eff = (sample_frames > MAX_K) ? MAX_K : sample_frames;
  assign k_m1  = k_eff - 1'b1;

  // Restoring divider step: (n-1) / (k-1), one quotient bit per cycle
  logic [CFG_W:0]   dshift;
  logic             dge;
  logic [CFG_W:0]   dtrial;
  logic [CFG_W-1:0] rem_div;
  logic [AW:0]      quo_sh;
  logic [AW-1:0]    quo_div;

  always_comb begin
    dshift  = {rem, quo[AW-1]};
    dge     = (dshift >= {1'b0, dv});
    dtrial  = dshift - {1'b0, dv};
    rem_div = dge ? dtrial[CFG_W-1:0] : dshift[CFG_W-1:0];
    quo_sh  = {quo, dge};
    quo_div = quo_sh[AW-1:0];
  end

  // Position advance: numerator grows by 2(n-1), denominator is 2(k-1)
  logic [CFG_W+1:0] r_sum;
  logic [CFG_W+1:0] d2;
  logic             carry;
  logic [CFG_W:0]   racc_next;
  logic [AW:0]      psum;
  logic [AW-1:0]    last_pos;
  logic [AW-1:0]    pos_next;

  always_comb begin
    r_sum     = {1'b0, racc} + {1'b0, rem, 1'b0};
    d2        = {1'b0, dv, 1'b0};
    carry     = (r_sum >= d2);
    racc_next = carry ? (CFG_W + 1)'(r_sum - d2) : (CFG_W + 1)'(r_sum);
    psum      = {1'b0, pos} + {1'b0, quo} + (AW + 1)'(carry);
    last_pos  = AW'(held - 1'b1);
    pos_next  = (psum > {1'b0, last_pos}) ? last_pos : AW'(psum);
  end

  // Sequencer, window state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      oldest    <= '0;
      held      <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (cmd_t'(s_tuser) == CMD_APPEND) begin
              oldest <= oldest_new;
              held   <= held_new;
            end else if (k_eff == '0 || held == '0) begin
              state <= ST_ERR;
            end else if (k_eff == CFG_W'(1)) begin
              pos   <= AW'(held - 1'b1);
              cnt   <= CFG_W'(1);
              state <= ST_READ;
            end else begin
              quo   <= AW'(held - 1'b1);
              rem   <= '0;
              dv    <= k_m1;
              racc  <= {1'b0, k_m1};
              pos   <= '0;
              cnt   <= k_eff;
              dcnt  <= DIV_STEPS;
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          quo  <= quo_div;
          rem  <= rem_div;
          dcnt <= dcnt - 1'b1;
          if (dcnt == DCW'(1)) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          // Read address is held, so RAM data stays valid while stalled
          if (out_free) begin
            out_tag   <= TAG_OUT_W'(ram_rdata);
            out_pos   <= POS_W'(pos);
            out_last  <= (cnt == CFG_W'(1));
            out_err   <= 1'b0;
            cnt       <= cnt - 1'b1;
            if (cnt == CFG_W'(1)) begin
              state <= ST_IDLE;
            end else begin
              pos   <= pos_next;
              racc  <= racc_next;
              state <= ST_READ;
            end
          end
        end
        ST_ERR: begin
          if (out_free) begin
            out_tag   <= '0;
            out_pos   <= '0;
            out_last  <= 1'b1;
            out_err   <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result beat valid: set on load, cleared once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Appends only happen between runs, so reads never race a write
  ufws_ram #(
    .WIDTH (TAG_WIDTH),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

FILE: rtl/ufws_checker.sv
`include "uniform_frame_window_sampler_core_defines.svh"

module ufws_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            s_tuser,   // [0] command
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ufws_pkg::OUT_DATA_W-1:0] m_tdata,   // [31:0] sampled_tag, [37:32] position
  input logic                            m_tlast,
  input logic                            m_tuser    // [0] error
);

  import ufws_pkg::*;

  // A stalled result beat holds
  `UFWS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "result beat changed while stalled")

  // An error result ends its run and carries no tag or position
  `UFWS_ASSERT_SAME(a_err_last, m_tvalid && m_tuser, m_tlast && (m_tdata == '0), "error beat not last or not zero")

  // A sample request leaves the input closed after it is accepted
  `UFWS_ASSERT_NEXT(a_sample_busy, s_tvalid && s_tready && (cmd_t'(s_tuser) == CMD_SAMPLE), !s_tready, "input open during a sampling run")

  // An append leaves the input open after it is accepted
  `UFWS_ASSERT_NEXT(a_append_one, s_tvalid && s_tready && (cmd_t'(s_tuser) == CMD_APPEND), s_tready, "input closed after an append")

endmodule

bind uniform_frame_window_sampler_core ufws_checker u_ufws_checker (.*);
